>>> rtl/wftl_pkg.sv
// ----------------------------------------------------------------------------
// wftl_pkg
// Shared types and constants for the wildcard flow table lookup block.
// ----------------------------------------------------------------------------
package wftl_pkg;

  // Operation codes carried on the input channel
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Ignore mask bit positions
  localparam int IGN_VM_BIT   = 0;
  localparam int IGN_OMAC_BIT = 1;
  localparam int IGN_VNI_BIT  = 2;
  localparam int IGN_IMAC_BIT = 3;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int VM_W      = 7;
  localparam int MAC_W     = 48;
  localparam int VNI_W     = 24;
  localparam int IGN_W     = 4;
  localparam int IRQ_W     = 8;
  localparam int IDX_OUT_W = 6;

  // One stored flow entry
  typedef struct packed {
    logic [IGN_W-1:0] ignore_mask;
    logic [VM_W-1:0]  vm_id;
    logic [MAC_W-1:0] outer_mac;
    logic [VNI_W-1:0] vni;
    logic [MAC_W-1:0] inner_mac;
    logic             irq_valid;
    logic [IRQ_W-1:0] irq;
  } entry_t;

  // Packet fields compared during a lookup
  typedef struct packed {
    logic [VM_W-1:0]  vm_id;
    logic [MAC_W-1:0] outer_mac;
    logic [VNI_W-1:0] vni;
    logic [MAC_W-1:0] inner_mac;
  } key_t;

  // One result item
  typedef struct packed {
    logic                 ok;
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 irq_valid;
    logic [IRQ_W-1:0]     irq_out;
  } result_t;

endpackage

>>> rtl/wftl_if.sv
// ----------------------------------------------------------------------------
// wftl_if
// Valid/ready channel interfaces for operations in and results out.
// ----------------------------------------------------------------------------
interface wftl_in_if;
  logic                            valid;
  logic                            ready;
  logic [wftl_pkg::OP_W-1:0]       opcode;
  logic [wftl_pkg::VM_W-1:0]       vm_id;
  logic [wftl_pkg::MAC_W-1:0]      outer_dst_mac;
  logic [wftl_pkg::VNI_W-1:0]      vni;
  logic [wftl_pkg::MAC_W-1:0]      inner_dst_mac;
  logic [wftl_pkg::IGN_W-1:0]      ignore_mask;
  logic                            with_irq;
  logic [wftl_pkg::IRQ_W-1:0]      irq;

  modport source (
    output valid, opcode, vm_id, outer_dst_mac, vni, inner_dst_mac,
           ignore_mask, with_irq, irq,
    input  ready
  );
  modport sink (
    input  valid, opcode, vm_id, outer_dst_mac, vni, inner_dst_mac,
           ignore_mask, with_irq, irq,
    output ready
  );
endinterface

interface wftl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [wftl_pkg::IDX_OUT_W-1:0]  entry_index;
  logic                            irq_valid;
  logic [wftl_pkg::IRQ_W-1:0]      irq_out;

  modport source (
    output valid, ok, entry_index, irq_valid, irq_out,
    input  ready
  );
  modport sink (
    input  valid, ok, entry_index, irq_valid, irq_out,
    output ready
  );
endinterface

>>> rtl/wftl_entry_mem.sv
// ----------------------------------------------------------------------------
// wftl_entry_mem
// Flow entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wftl_entry_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  wftl_pkg::entry_t    wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output wftl_pkg::entry_t    rd_data
);

  wftl_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/wftl_match.sv
// ----------------------------------------------------------------------------
// wftl_match
// Wildcard compare of one stored entry against the packet key.
// ----------------------------------------------------------------------------
module wftl_match (
  input  wftl_pkg::entry_t entry,
  input  wftl_pkg::key_t   key,
  output logic             hit
);

  logic vm_ok;
  logic omac_ok;
  logic vni_ok;
  logic imac_ok;

  // A field passes when ignored or equal
  assign vm_ok   = entry.ignore_mask[wftl_pkg::IGN_VM_BIT]   || (entry.vm_id == key.vm_id);
  assign omac_ok = entry.ignore_mask[wftl_pkg::IGN_OMAC_BIT] ||
                   (entry.outer_mac == key.outer_mac);
  assign vni_ok  = entry.ignore_mask[wftl_pkg::IGN_VNI_BIT]  || (entry.vni == key.vni);
  assign imac_ok = entry.ignore_mask[wftl_pkg::IGN_IMAC_BIT] ||
                   (entry.inner_mac == key.inner_mac);

  assign hit = vm_ok && omac_ok && vni_ok && imac_ok;

endmodule

>>> rtl/wildcard_flow_table_lookup_core.sv
// ----------------------------------------------------------------------------
// wildcard_flow_table_lookup_core
// Wildcard flow classifier table with add, clear and newest-first lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per transfer (lookup, add, clear); out_ch
//   returns exactly one result per operation, in order.
//   Add writes the entry memory in the transfer cycle; add, clear and the
//   unused opcode register their result at the transfer, then move it to
//   the output register from ST_RESP. A lookup reads the entry memory one
//   slot per cycle, newest slot first, through the single read port, and
//   stops at the first hit or after the oldest slot (a miss); on an empty
//   table it skips the scan and reports a miss.
//   One operation is in work at a time; in_ch.ready is high while the block
//   is idle, also while a finished result still waits in the output register.
//   If out_ch is stalled with a result pending, the next result is held
//   internally until the output register frees up.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; entry contents are not cleared, only the entry count.
// ----------------------------------------------------------------------------
module wildcard_flow_table_lookup_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  wftl_in_if.sink     in_ch,
  wftl_out_if.source  out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam int EXT_W = IDX_W + wftl_pkg::IDX_OUT_W;

  // Controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]              state_r;
  logic [CNT_W-1:0]        count_r;
  logic                    issuing_r;
  logic                    cmp_vld_r;
  logic                    cmp_last_r;
  logic [IDX_W-1:0]        issue_idx_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  wftl_pkg::key_t          key_r;
  wftl_pkg::result_t       res_r;
  wftl_pkg::result_t       res_nxt;
  logic                    res_ld;
  logic                    out_valid_r;
  wftl_pkg::result_t       out_res_r;

  logic                    accept;
  logic                    table_full;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    wr_en;
  wftl_pkg::entry_t        wr_entry;
  logic                    rd_en;
  wftl_pkg::entry_t        rd_entry;
  logic                    hit;
  logic                    out_free;
  logic [EXT_W-1:0]        add_slot_ext;
  logic [EXT_W-1:0]        hit_slot_ext;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign table_full = (count_r == DEPTH_CNT);
  assign cnt_m1     = count_r - 1'b1;
  assign out_free   = !out_valid_r || out_ch.ready;

  // Slot numbers shown on the result, low six bits only
  assign add_slot_ext = {{wftl_pkg::IDX_OUT_W{1'b0}}, count_r[IDX_W-1:0]};
  assign hit_slot_ext = {{wftl_pkg::IDX_OUT_W{1'b0}}, cmp_idx_r};

  // New entry; ignored fields are stored as zero
  assign wr_en = accept && (in_ch.opcode == wftl_pkg::OP_ADD) && !table_full;
  always_comb begin
    wr_entry.ignore_mask = in_ch.ignore_mask;
    wr_entry.vm_id       = in_ch.ignore_mask[wftl_pkg::IGN_VM_BIT] ?
                           '0 : in_ch.vm_id;
    wr_entry.outer_mac   = in_ch.ignore_mask[wftl_pkg::IGN_OMAC_BIT] ?
                           '0 : in_ch.outer_dst_mac;
    wr_entry.vni         = in_ch.ignore_mask[wftl_pkg::IGN_VNI_BIT] ?
                           '0 : in_ch.vni;
    wr_entry.inner_mac   = in_ch.ignore_mask[wftl_pkg::IGN_IMAC_BIT] ?
                           '0 : in_ch.inner_dst_mac;
    wr_entry.irq_valid   = in_ch.with_irq;
    wr_entry.irq         = in_ch.with_irq ? in_ch.irq : '0;
  end

  assign rd_en = (state_r == ST_SCAN) && issuing_r;

  wftl_entry_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (issue_idx_r),
    .rd_data (rd_entry)
  );

  wftl_match u_match (
    .entry (rd_entry),
    .key   (key_r),
    .hit   (hit)
  );

  // Result of the current operation
  always_comb begin
    res_nxt = '0;
    res_ld  = 1'b0;
    if (state_r == ST_IDLE && accept) begin
      unique case (in_ch.opcode)
        wftl_pkg::OP_LOOKUP: begin
          res_ld = (count_r == '0);
        end
        wftl_pkg::OP_ADD: begin
          res_ld = 1'b1;
          res_nxt.ok = !table_full;
          res_nxt.entry_index = table_full ? '0 : add_slot_ext[wftl_pkg::IDX_OUT_W-1:0];
        end
        wftl_pkg::OP_CLEAR: begin
          res_ld = 1'b1;
          res_nxt.ok = 1'b1;
        end
        default: begin
          res_ld = 1'b1;
        end
      endcase
    end else if (state_r == ST_SCAN && cmp_vld_r) begin
      if (hit) begin
        res_ld = 1'b1;
        res_nxt.ok = 1'b1;
        res_nxt.entry_index = hit_slot_ext[wftl_pkg::IDX_OUT_W-1:0];
        res_nxt.irq_valid = rd_entry.irq_valid;
        res_nxt.irq_out = rd_entry.irq_valid ? rd_entry.irq : '0;
      end else if (cmp_last_r) begin
        res_ld = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issuing_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.opcode == wftl_pkg::OP_LOOKUP && count_r != '0) begin
              state_r   <= ST_SCAN;
              issuing_r <= 1'b1;
            end else begin
              state_r <= ST_RESP;
            end
            if (wr_en) begin
              count_r <= count_r + 1'b1;
            end else if (in_ch.opcode == wftl_pkg::OP_CLEAR) begin
              count_r <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (res_ld) begin
            state_r   <= ST_RESP;
            issuing_r <= 1'b0;
            cmp_vld_r <= 1'b0;
          end else begin
            cmp_vld_r <= issuing_r;
            if (issuing_r && issue_idx_r == '0) begin
              issuing_r <= 1'b0;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      // Output register
      if (state_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.vm_id     <= in_ch.vm_id;
      key_r.outer_mac <= in_ch.outer_dst_mac;
      key_r.vni       <= in_ch.vni;
      key_r.inner_mac <= in_ch.inner_dst_mac;
    end
    if (state_r == ST_IDLE && accept) begin
      issue_idx_r <= cnt_m1[IDX_W-1:0];
    end else if (rd_en && issue_idx_r != '0) begin
      issue_idx_r <= issue_idx_r - 1'b1;
    end
    cmp_idx_r  <= issue_idx_r;
    cmp_last_r <= (issue_idx_r == '0);
    if (res_ld) begin
      res_r <= res_nxt;
    end
    if (state_r == ST_RESP && out_free) begin
      out_res_r <= res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_res_r.ok;
  assign out_ch.entry_index = out_res_r.entry_index;
  assign out_ch.irq_valid   = out_res_r.irq_valid;
  assign out_ch.irq_out     = out_res_r.irq_out;

endmodule

>>> rtl/wftl_checker.sv
// ----------------------------------------------------------------------------
// wftl_checker
// Port-level checks on the result channel of the flow table core.
// ----------------------------------------------------------------------------
module wftl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_ok,
  input logic [wftl_pkg::IDX_OUT_W-1:0]   out_entry_index,
  input logic                             out_irq_valid,
  input logic [wftl_pkg::IRQ_W-1:0]       out_irq_out
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_entry_index) && $stable(out_irq_valid) && $stable(out_irq_out))
    else $error("result changed while stalled");

  // A failed operation reports nothing else
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_entry_index == '0 && !out_irq_valid)
    else $error("failed result carries slot or interrupt");

  // Interrupt only on a hit, number zero without one
  a_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_irq_valid |-> out_irq_out == '0)
    else $error("interrupt number without valid flag");

  // Reset drops any pending result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_flow_table_lookup_core wftl_checker u_wftl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ok          (out_ch.ok),
  .out_entry_index (out_ch.entry_index),
  .out_irq_valid   (out_ch.irq_valid),
  .out_irq_out     (out_ch.irq_out)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard flow table lookup core. Operations go
// in over the input channel, and a local model of the flow table predicts the
// result of each accepted transfer. Every result transfer is compared field
// by field with the oldest prediction. Directed tests come first: empty
// table, exact match, wildcards, table full and a long output stall. Random
// sessions follow: add a run of entries, then look up keys mostly near stored ones.
// ----------------------------------------------------------------------------
module tb;

  // Package names used throughout the bench
  localparam int OP_W         = wftl_pkg::OP_W;
  localparam int VM_W         = wftl_pkg::VM_W;
  localparam int MAC_W        = wftl_pkg::MAC_W;
  localparam int VNI_W        = wftl_pkg::VNI_W;
  localparam int IGN_W        = wftl_pkg::IGN_W;
  localparam int IRQ_W        = wftl_pkg::IRQ_W;
  localparam int IDX_OUT_W    = wftl_pkg::IDX_OUT_W;
  localparam int IGN_VM_BIT   = wftl_pkg::IGN_VM_BIT;
  localparam int IGN_OMAC_BIT = wftl_pkg::IGN_OMAC_BIT;
  localparam int IGN_VNI_BIT  = wftl_pkg::IGN_VNI_BIT;
  localparam int IGN_IMAC_BIT = wftl_pkg::IGN_IMAC_BIT;
  localparam logic [OP_W-1:0] OP_LOOKUP = wftl_pkg::OP_LOOKUP;
  localparam logic [OP_W-1:0] OP_ADD    = wftl_pkg::OP_ADD;
  localparam logic [OP_W-1:0] OP_CLEAR  = wftl_pkg::OP_CLEAR;
  typedef wftl_pkg::entry_t  entry_t;
  typedef wftl_pkg::result_t result_t;

  localparam int TABLE_DEPTH  = 64;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 800000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One operation as presented on the input channel
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [VM_W-1:0]  vm_id;
    logic [MAC_W-1:0] outer_mac;
    logic [VNI_W-1:0] vni;
    logic [MAC_W-1:0] inner_mac;
    logic [IGN_W-1:0] ignore_mask;
    logic             with_irq;
    logic [IRQ_W-1:0] irq;
  } flow_op_t;

  logic clk = 1'b0;
  logic rst_n;

  wftl_in_if  in_if();
  wftl_out_if out_if();

  wildcard_flow_table_lookup_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Local copy of the flow table
  entry_t      flow_tbl [TABLE_DEPTH];
  int unsigned flow_count = 0;

  result_t     pending_results [$];
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_reqs    = 0;
  int          sent_items   = 0;
  int          error_count  = 0;
  int unsigned cycle_count  = 0;

  always #CLK_HALF clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Predict the result of one operation and update the local table
  function automatic result_t table_response(flow_op_t op);
    result_t r;
    entry_t  e;
    logic    hit;
    r = '0;
    case (op.opcode)
      OP_LOOKUP: begin
        // newest entry first, first hit wins
        for (int i = int'(flow_count) - 1; i >= 0; i--) begin
          e = flow_tbl[i];
          hit = (e.ignore_mask[IGN_VM_BIT]   || e.vm_id == op.vm_id) &&
                (e.ignore_mask[IGN_OMAC_BIT] || e.outer_mac == op.outer_mac) &&
                (e.ignore_mask[IGN_VNI_BIT]  || e.vni == op.vni) &&
                (e.ignore_mask[IGN_IMAC_BIT] || e.inner_mac == op.inner_mac);
          if (hit) begin
            r.ok          = 1'b1;
            r.entry_index = i[IDX_OUT_W-1:0];
            r.irq_valid   = e.irq_valid;
            r.irq_out     = e.irq;
            break;
          end
        end
      end
      OP_ADD: begin
        if (flow_count < TABLE_DEPTH) begin
          // ignored fields are stored as zero
          e.ignore_mask = op.ignore_mask;
          e.vm_id       = op.ignore_mask[IGN_VM_BIT]   ? '0 : op.vm_id;
          e.outer_mac   = op.ignore_mask[IGN_OMAC_BIT] ? '0 : op.outer_mac;
          e.vni         = op.ignore_mask[IGN_VNI_BIT]  ? '0 : op.vni;
          e.inner_mac   = op.ignore_mask[IGN_IMAC_BIT] ? '0 : op.inner_mac;
          e.irq_valid   = op.with_irq;
          e.irq         = op.with_irq ? op.irq : '0;
          flow_tbl[flow_count] = e;
          r.ok          = 1'b1;
          r.entry_index = flow_count[IDX_OUT_W-1:0];
          flow_count++;
        end
      end
      OP_CLEAR: begin
        flow_count = 0;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random field value biased toward zero, small values and all ones
  function automatic logic [63:0] rand_bits(int unsigned w);
    logic [63:0] ones;
    ones = (64'd1 << w) - 64'd1;
    case ($urandom_range(3))
      0:       return 64'($urandom_range(3));
      1:       return ones;
      default: return {$urandom, $urandom} & ones;
    endcase
  endfunction

  function automatic flow_op_t mk_add(logic [VM_W-1:0] vm, logic [MAC_W-1:0] omac,
                                      logic [VNI_W-1:0] vni, logic [MAC_W-1:0] imac,
                                      logic [IGN_W-1:0] mask, logic wirq,
                                      logic [IRQ_W-1:0] irq);
    flow_op_t op;
    op.opcode      = OP_ADD;
    op.vm_id       = vm;
    op.outer_mac   = omac;
    op.vni         = vni;
    op.inner_mac   = imac;
    op.ignore_mask = mask;
    op.with_irq    = wirq;
    op.irq         = irq;
    return op;
  endfunction

  // Lookup; the add-only fields carry random junk
  function automatic flow_op_t mk_lookup(logic [VM_W-1:0] vm, logic [MAC_W-1:0] omac,
                                         logic [VNI_W-1:0] vni, logic [MAC_W-1:0] imac);
    flow_op_t op;
    op = mk_add(vm, omac, vni, imac, IGN_W'($urandom), 1'($urandom), IRQ_W'($urandom));
    op.opcode = OP_LOOKUP;
    return op;
  endfunction

  // Clear or unused opcode, all other fields random
  function automatic flow_op_t mk_ctl(logic [OP_W-1:0] opc);
    flow_op_t op;
    op = mk_lookup(VM_W'($urandom), MAC_W'({$urandom, $urandom}), VNI_W'($urandom),
                   MAC_W'({$urandom, $urandom}));
    op.opcode = opc;
    return op;
  endfunction

  function automatic flow_op_t rand_lookup();
    return mk_lookup(VM_W'(rand_bits(VM_W)), MAC_W'(rand_bits(MAC_W)),
                     VNI_W'(rand_bits(VNI_W)), MAC_W'(rand_bits(MAC_W)));
  endfunction

  function automatic flow_op_t rand_add();
    logic [IGN_W-1:0] mask;
    mask = ($urandom_range(1) == 0) ? '0 : IGN_W'($urandom_range(15));
    return mk_add(VM_W'(rand_bits(VM_W)), MAC_W'(rand_bits(MAC_W)),
                  VNI_W'(rand_bits(VNI_W)), MAC_W'(rand_bits(MAC_W)),
                  mask, 1'($urandom), IRQ_W'($urandom));
  endfunction

  // Lookup built from a stored entry, sometimes with one bit flipped
  function automatic flow_op_t lookup_near_entry();
    entry_t   e;
    flow_op_t op;
    if (flow_count == 0) return rand_lookup();
    e = flow_tbl[$urandom_range(flow_count - 1)];
    op = rand_lookup();
    if (!e.ignore_mask[IGN_VM_BIT])   op.vm_id     = e.vm_id;
    if (!e.ignore_mask[IGN_OMAC_BIT]) op.outer_mac = e.outer_mac;
    if (!e.ignore_mask[IGN_VNI_BIT])  op.vni       = e.vni;
    if (!e.ignore_mask[IGN_IMAC_BIT]) op.inner_mac = e.inner_mac;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       op.vm_id     = op.vm_id ^ (VM_W'(1) << $urandom_range(VM_W - 1));
        1:       op.outer_mac = op.outer_mac ^ (MAC_W'(1) << $urandom_range(MAC_W - 1));
        2:       op.vni       = op.vni ^ (VNI_W'(1) << $urandom_range(VNI_W - 1));
        default: op.inner_mac = op.inner_mac ^ (MAC_W'(1) << $urandom_range(MAC_W - 1));
      endcase
    end
    return op;
  endfunction

  // Offer one operation and wait for its transfer
  task automatic send_op(input flow_op_t op);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op.opcode;
    in_if.vm_id         <= op.vm_id;
    in_if.outer_dst_mac <= op.outer_mac;
    in_if.vni           <= op.vni;
    in_if.inner_dst_mac <= op.inner_mac;
    in_if.ignore_mask   <= op.ignore_mask;
    in_if.with_irq      <= op.with_irq;
    in_if.irq           <= op.irq;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(table_response(op));
    sent_items++;
  endtask

  // Result side: random stalls, long hold-off on request, field checks
  initial begin : result_side
    int      hold_served;
    int      hold_left;
    result_t want;
    hold_served = 0;
    hold_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: ok %0d entry_index %0d irq_valid %0d irq_out %0d",
                 out_if.ok, out_if.entry_index, out_if.irq_valid, out_if.irq_out);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, out_if.ok);
            error_count++;
          end
          if (out_if.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d",
                   want.entry_index, out_if.entry_index);
            error_count++;
          end
          if (out_if.irq_valid !== want.irq_valid) begin
            $error("irq_valid: expected %0d, actual %0d", want.irq_valid, out_if.irq_valid);
            error_count++;
          end
          if (out_if.irq_out !== want.irq_out) begin
            $error("irq_out: expected %0d, actual %0d", want.irq_out, out_if.irq_out);
            error_count++;
          end
        end
      end
      if (hold_left == 0 && hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Empty table: lookup misses, unused opcode answers all zero
  task automatic test_empty_table();
    send_op(mk_ctl(OP_CLEAR));
    send_op(mk_lookup('1, '1, '1, '1));
    send_op(mk_ctl(OP_UNUSED));
  endtask

  // Exact matches on extreme field values, with and without an interrupt
  task automatic test_exact_match();
    send_op(mk_add('1, '1, '1, '1, '0, 1'b1, '1));
    send_op(mk_add('0, '0, '0, '0, '0, 1'b0, '1));
    send_op(mk_lookup('1, '1, '1, '1));
    send_op(mk_lookup('0, '0, '0, '0));
    send_op(mk_lookup(7'h3e, '1, '1, '1));
    send_op(mk_lookup('0, '0, 24'd1, '0));
  endtask

  // One ignore bit per entry; flipping that field only hits that entry
  task automatic test_wildcards();
    logic [VM_W-1:0]  vm;
    logic [MAC_W-1:0] omac;
    logic [VNI_W-1:0] vni;
    logic [MAC_W-1:0] imac;
    vm   = 7'h2a;
    omac = 48'h0123_4567_89ab;
    vni  = 24'habcdef;
    imac = 48'hfedc_ba98_7654;
    for (int b = 0; b < IGN_W; b++)
      send_op(mk_add(vm, omac, vni, imac, IGN_W'(1) << b, 1'b1, IRQ_W'(b)));
    send_op(mk_lookup(vm, omac, vni, imac));
    send_op(mk_lookup(vm ^ 7'h40, omac, vni, imac));
    send_op(mk_lookup(vm, omac ^ (MAC_W'(1) << 47), vni, imac));
    send_op(mk_lookup(vm, omac, vni ^ 24'd1, imac));
    send_op(mk_lookup(vm, omac, vni, imac ^ (MAC_W'(1) << 47)));
    send_op(mk_ctl(OP_UNUSED));
    // fully wildcarded entry matches anything
    send_op(mk_add(vm, omac, vni, imac, '1, 1'b1, '0));
    send_op(rand_lookup());
  endtask

  // Fill every slot, then one add too many
  task automatic test_table_full();
    send_op(mk_ctl(OP_CLEAR));
    repeat (TABLE_DEPTH) send_op(rand_add());
    send_op(rand_add());
    send_op(lookup_near_entry());
    send_op(rand_lookup());
    send_op(mk_ctl(OP_CLEAR));
    send_op(mk_lookup('1, '1, '1, '1));
  endtask

  // Output stalled for a long stretch while operations keep coming
  task automatic test_backpressure();
    send_op(mk_ctl(OP_CLEAR));
    repeat (6) send_op(rand_add());
    hold_reqs++;
    repeat (12) send_op(lookup_near_entry());
  endtask

  // Random sessions: optional clear, a run of adds, then mostly near lookups
  task automatic test_random(int snd_pct, int rcv_pct, int items);
    int stop_at;
    int n_add;
    int n_look;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      if ($urandom_range(4) != 0) send_op(mk_ctl(OP_CLEAR));
      n_add = ($urandom_range(7) == 0) ? $urandom_range(TABLE_DEPTH + 6, 40)
                                       : $urandom_range(12, 1);
      repeat (n_add) send_op(rand_add());
      n_look = $urandom_range(16, 4);
      repeat (n_look) begin
        case ($urandom_range(19))
          0:       send_op(mk_ctl(OP_UNUSED));
          1:       send_op(rand_add());
          2, 3, 4: send_op(rand_lookup());
          default: send_op(lookup_near_entry());
        endcase
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.opcode        <= OP_LOOKUP;
    in_if.vm_id         <= '0;
    in_if.outer_dst_mac <= '0;
    in_if.vni           <= '0;
    in_if.inner_dst_mac <= '0;
    in_if.ignore_mask   <= '0;
    in_if.with_irq      <= 1'b0;
    in_if.irq           <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_exact_match();
    test_wildcards();
    test_table_full();
    test_backpressure();
    test_random(14, 49, RANDOM_ITEMS / 3);
    test_random(49, 14, RANDOM_ITEMS / 3);
    test_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/wftl_pkg.sv
rtl/wftl_if.sv
rtl/wftl_entry_mem.sv
rtl/wftl_match.sv
rtl/wildcard_flow_table_lookup_core.sv
rtl/wftl_checker.sv
tb/tb.sv
